/* sv/info_frame_deframer_top_macros.svh */
// assertion helpers for the deframer, clocked on clk with async reset arst_n
`ifndef INFO_FRAME_DEFRAMER_TOP_MACROS_SVH
`define INFO_FRAME_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication
`define IFD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define IFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* sv/ifd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types and byte codes of the information frame deframer.
// ----------------------------------------------------------------------------
package ifd_pkg;

	typedef enum logic [2:0] {
		ST_HUNT = 3'd0,
		ST_FLAG = 3'd1,
		ST_ADDR = 3'd2,
		ST_CTRL = 3'd3,
		ST_BODY = 3'd4,
		ST_ESC  = 3'd5
	} hunt_state_t;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_REJECT = 2'd2,
		KIND_ABORT  = 2'd3
	} kind_t;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ADDR_BYTE = 8'h03;
	localparam logic [7:0] CTRL_I0   = 8'h00;
	localparam logic [7:0] CTRL_I1   = 8'h80;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_XOR   = 8'h20;
	localparam logic [7:0] RR_SEQ1   = 8'hAA;
	localparam logic [7:0] RR_SEQ0   = 8'hAB;
	localparam logic [7:0] REJ_SEQ1  = 8'h54;
	localparam logic [7:0] REJ_SEQ0  = 8'h55;

endpackage

/* sv/info_frame_deframer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// info_frame_deframer_top
// Byte-stuffed information frame receiver: header check, unstuffing,
// one-byte hold-back of the body and XOR check at the closing flag.
// ----------------------------------------------------------------------------
// a byte waits in the input register; the frame state update then loads its result
// into the output register, and out_stall can hold the byte in the input register
// throughput: one byte per cycle while out_stall does not hold a pending result
// reset: arst_n clears the hunt state, frame counters and sequence bit at once
// ----------------------------------------------------------------------------
`include "info_frame_deframer_top_macros.svh"

module info_frame_deframer_top #(
	parameter int MAX_PAYLOAD = 4096,
	localparam int CW = $clog2(MAX_PAYLOAD + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    rx_byte,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    kind,
	output logic [7:0]    out_byte,
	output logic [CW-1:0] payload_count
);

	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PAYLOAD);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// frame state
	ifd_pkg::hunt_state_t state_q, state_d;
	logic [7:0]    hdr_ctrl_q, hdr_ctrl_d;
	logic [7:0]    held_q, held_d;
	logic          held_valid_q, held_valid_d;
	logic [7:0]    xor_q, xor_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          seq_q, seq_d;

	// result of the item in s1
	logic          res_valid;
	ifd_pkg::kind_t res_kind;
	logic [7:0]    res_byte;
	logic [CW-1:0] res_cnt;

	// output register
	logic          out_valid_q;
	ifd_pkg::kind_t kind_q;
	logic [7:0]    out_byte_q;
	logic [CW-1:0] cnt_out_q;

	logic adv;
	logic take;
	logic [7:0] take_byte;
	logic ok;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_comb begin
		state_d      = state_q;
		hdr_ctrl_d   = hdr_ctrl_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		xor_d        = xor_q;
		cnt_d        = cnt_q;
		seq_d        = seq_q;
		res_valid    = 1'b0;
		res_kind     = ifd_pkg::KIND_DATA;
		res_byte     = 8'h00;
		res_cnt      = cnt_q;
		take         = 1'b0;
		take_byte    = byte_s1;
		ok           = held_valid_q && (xor_q == held_q);
		unique case (state_q)
			ifd_pkg::ST_HUNT: begin
				if (byte_s1 == ifd_pkg::FLAG_BYTE) begin
					state_d = ifd_pkg::ST_FLAG;
				end
			end
			ifd_pkg::ST_FLAG: begin
				if (byte_s1 == ifd_pkg::ADDR_BYTE) begin
					state_d = ifd_pkg::ST_ADDR;
				end else if (byte_s1 != ifd_pkg::FLAG_BYTE) begin
					state_d = ifd_pkg::ST_HUNT;
				end
			end
			ifd_pkg::ST_ADDR: begin
				if (byte_s1 == ifd_pkg::CTRL_I0 || byte_s1 == ifd_pkg::CTRL_I1) begin
					hdr_ctrl_d = byte_s1;
					state_d    = ifd_pkg::ST_CTRL;
				end else if (byte_s1 == ifd_pkg::FLAG_BYTE) begin
					state_d = ifd_pkg::ST_FLAG;
				end else begin
					state_d = ifd_pkg::ST_HUNT;
				end
			end
			ifd_pkg::ST_CTRL: begin
				if (byte_s1 == (ifd_pkg::ADDR_BYTE ^ hdr_ctrl_q)) begin
					held_d       = 8'h00;
					held_valid_d = 1'b0;
					xor_d        = 8'h00;
					cnt_d        = '0;
					state_d      = ifd_pkg::ST_BODY;
				end else if (byte_s1 == ifd_pkg::FLAG_BYTE) begin
					state_d = ifd_pkg::ST_FLAG;
				end else begin
					state_d = ifd_pkg::ST_HUNT;
				end
			end
			ifd_pkg::ST_BODY: begin
				if (byte_s1 == ifd_pkg::FLAG_BYTE) begin
					res_valid = 1'b1;
					if (ok) begin
						res_kind = ifd_pkg::KIND_ACCEPT;
						res_byte = seq_q ? ifd_pkg::RR_SEQ1 : ifd_pkg::RR_SEQ0;
						seq_d    = !seq_q;
					end else begin
						res_kind = ifd_pkg::KIND_REJECT;
						res_byte = seq_q ? ifd_pkg::REJ_SEQ1 : ifd_pkg::REJ_SEQ0;
					end
					held_d       = 8'h00;
					held_valid_d = 1'b0;
					xor_d        = 8'h00;
					cnt_d        = '0;
					state_d      = ifd_pkg::ST_HUNT;
				end else if (byte_s1 == ifd_pkg::ESC_BYTE) begin
					state_d = ifd_pkg::ST_ESC;
				end else begin
					take = 1'b1;
				end
			end
			ifd_pkg::ST_ESC: begin
				if (byte_s1 == (ifd_pkg::FLAG_BYTE ^ ifd_pkg::ESC_XOR) ||
					byte_s1 == (ifd_pkg::ESC_BYTE ^ ifd_pkg::ESC_XOR)) begin
					take      = 1'b1;
					take_byte = byte_s1 ^ ifd_pkg::ESC_XOR;
					state_d   = ifd_pkg::ST_BODY;
				end else begin
					res_valid    = 1'b1;
					res_kind     = ifd_pkg::KIND_ABORT;
					held_d       = 8'h00;
					held_valid_d = 1'b0;
					xor_d        = 8'h00;
					cnt_d        = '0;
					state_d      = ifd_pkg::ST_HUNT;
				end
			end
			default: begin
				state_d = ifd_pkg::ST_HUNT;
			end
		endcase
		// body byte: release the held one, keep the new one back
		if (take) begin
			if (held_valid_q) begin
				xor_d = xor_q ^ held_q;
				if (cnt_q < CNT_MAX) begin
					cnt_d = cnt_q + 1'b1;
				end
				res_valid = 1'b1;
				res_kind  = ifd_pkg::KIND_DATA;
				res_byte  = held_q;
				res_cnt   = cnt_d;
			end
			held_d       = take_byte;
			held_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ifd_pkg::ST_HUNT;
			hdr_ctrl_q   <= 8'h00;
			held_q       <= 8'h00;
			held_valid_q <= 1'b0;
			xor_q        <= 8'h00;
			cnt_q        <= '0;
			seq_q        <= 1'b0;
		end else if (adv) begin
			state_q      <= state_d;
			hdr_ctrl_q   <= hdr_ctrl_d;
			held_q       <= held_d;
			held_valid_q <= held_valid_d;
			xor_q        <= xor_d;
			cnt_q        <= cnt_d;
			seq_q        <= seq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			kind_q     <= res_kind;
			out_byte_q <= res_byte;
			cnt_out_q  <= res_cnt;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign out_byte      = out_byte_q;
	assign payload_count = cnt_out_q;

	// a count only grows while a byte is held back
	`IFD_ASSERT_IMPL(a_cnt_needs_held, !held_valid_q, cnt_q == '0)
	// a released payload byte is always counted
	`IFD_ASSERT_IMPL(a_data_counted, out_valid_q && kind_q == ifd_pkg::KIND_DATA,
		cnt_out_q != '0)
	// an abort carries no byte
	`IFD_ASSERT_IMPL(a_abort_zero, out_valid_q && kind_q == ifd_pkg::KIND_ABORT,
		out_byte_q == 8'h00)
	// an accepted frame flips the sequence bit
	`IFD_ASSERT_NEXT(a_seq_toggle, adv && res_valid && res_kind == ifd_pkg::KIND_ACCEPT,
		seq_q != $past(seq_q))

endmodule

/* bench/info_frame_deframer_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// info_frame_deframer_top_test
// Feeds byte-stuffed frames, broken headers, bad escapes and line noise into
// the deframer and checks every result item against an in-bench deframer.
// ----------------------------------------------------------------------------
module info_frame_deframer_top_test;

	localparam int COUNT_W = 13;
	localparam int COUNT_MAX = 4096;
	localparam int STALL_LIMIT = 4000;
	localparam int CHOKE_CYCLES = 300;
	localparam int CHOKE_AT = 400;
	localparam int RANDOM_BYTES = 1030;

	typedef struct packed {
		ifd_pkg::kind_t kind;
		logic [7:0] data;
		logic [COUNT_W-1:0] count;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic [COUNT_W-1:0] payload_count;

	info_frame_deframer_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.out_byte(out_byte),
		.payload_count(payload_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// bytes waiting to go on the line, and results the deframer still owes
	logic [7:0] line_bytes[$];
	frame_result_t due_results[$];
	frame_result_t head_result;

	int bytes_sent = 0;
	int bytes_in;
	int mismatches = 0;
	int idle_cycles;
	int choke_left;
	bit choked;
	int n_data = 0, n_accept = 0, n_reject = 0, n_abort = 0, top_count = 0;

	// in-bench deframer state
	ifd_pkg::hunt_state_t rx_state = ifd_pkg::ST_HUNT;
	logic [7:0] hdr_ctrl = 8'h00;
	logic [7:0] held_b = 8'h00;
	bit held_ok = 1'b0;
	logic [7:0] xor_acc = 8'h00;
	logic [COUNT_W-1:0] frame_count = '0;
	bit seq_bit = 1'b0;

	function automatic int idle_pct(input int n);
		return (n >= 700 && n < 900) ? 0 : 34;
	endfunction

	task automatic owe(input ifd_pkg::kind_t k, input logic [7:0] d);
		due_results.push_back('{kind: k, data: d, count: frame_count});
	endtask

	task automatic clear_frame();
		held_b = 8'h00;
		held_ok = 1'b0;
		xor_acc = 8'h00;
		frame_count = '0;
	endtask

	// unstuffed body byte: release the held one, hold this one
	task automatic take_body(input logic [7:0] b);
		if (held_ok) begin
			xor_acc = xor_acc ^ held_b;
			if (frame_count < COUNT_MAX)
				frame_count = frame_count + 1'b1;
			owe(ifd_pkg::KIND_DATA, held_b);
		end
		held_b = b;
		held_ok = 1'b1;
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		case (rx_state)
			ifd_pkg::ST_HUNT: begin
				if (b == ifd_pkg::FLAG_BYTE)
					rx_state = ifd_pkg::ST_FLAG;
			end
			ifd_pkg::ST_FLAG: begin
				if (b == ifd_pkg::ADDR_BYTE)
					rx_state = ifd_pkg::ST_ADDR;
				else if (b != ifd_pkg::FLAG_BYTE)
					rx_state = ifd_pkg::ST_HUNT;
			end
			ifd_pkg::ST_ADDR: begin
				if (b == ifd_pkg::CTRL_I0 || b == ifd_pkg::CTRL_I1) begin
					hdr_ctrl = b;
					rx_state = ifd_pkg::ST_CTRL;
				end else if (b == ifd_pkg::FLAG_BYTE) begin
					rx_state = ifd_pkg::ST_FLAG;
				end else begin
					rx_state = ifd_pkg::ST_HUNT;
				end
			end
			ifd_pkg::ST_CTRL: begin
				if (b == (ifd_pkg::ADDR_BYTE ^ hdr_ctrl)) begin
					clear_frame();
					rx_state = ifd_pkg::ST_BODY;
				end else if (b == ifd_pkg::FLAG_BYTE) begin
					rx_state = ifd_pkg::ST_FLAG;
				end else begin
					rx_state = ifd_pkg::ST_HUNT;
				end
			end
			ifd_pkg::ST_BODY: begin
				if (b == ifd_pkg::FLAG_BYTE) begin
					// closing flag: held byte is the check
					if (held_ok && xor_acc == held_b) begin
						owe(ifd_pkg::KIND_ACCEPT, seq_bit ? ifd_pkg::RR_SEQ1 : ifd_pkg::RR_SEQ0);
						seq_bit = ~seq_bit;
					end else begin
						owe(ifd_pkg::KIND_REJECT,
							seq_bit ? ifd_pkg::REJ_SEQ1 : ifd_pkg::REJ_SEQ0);
					end
					clear_frame();
					rx_state = ifd_pkg::ST_HUNT;
				end else if (b == ifd_pkg::ESC_BYTE) begin
					rx_state = ifd_pkg::ST_ESC;
				end else begin
					take_body(b);
				end
			end
			ifd_pkg::ST_ESC: begin
				if (b == (ifd_pkg::FLAG_BYTE ^ ifd_pkg::ESC_XOR) ||
					b == (ifd_pkg::ESC_BYTE ^ ifd_pkg::ESC_XOR)) begin
					rx_state = ifd_pkg::ST_BODY;
					take_body(b ^ ifd_pkg::ESC_XOR);
				end else begin
					owe(ifd_pkg::KIND_ABORT, 8'h00);
					clear_frame();
					rx_state = ifd_pkg::ST_HUNT;
				end
			end
			default: rx_state = ifd_pkg::ST_HUNT;
		endcase
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
	endtask

	// line driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
			bytes_in <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				deframe_byte(rx_byte);
				bytes_in <= bytes_in + 1;
			end
			if (!in_valid || !in_stall) begin
				if (line_bytes.size() != 0 && $urandom_range(99) >= idle_pct(bytes_in)) begin
					in_valid <= 1'b1;
					rx_byte <= line_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver, with one long hold-off so the deframer backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			choke_left <= 0;
			choked <= 1'b0;
		end else if (choke_left != 0) begin
			out_stall <= 1'b1;
			choke_left <= choke_left - 1;
		end else if (!choked && bytes_in >= CHOKE_AT) begin
			out_stall <= 1'b1;
			choke_left <= CHOKE_CYCLES;
			choked <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct(bytes_in));
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				report_mismatch("result with nothing due, kind", int'(kind), -1);
			end else begin
				head_result = due_results.pop_front();
				if (kind != head_result.kind)
					report_mismatch("kind", int'(kind), int'(head_result.kind));
				if (out_byte != head_result.data)
					report_mismatch("out_byte", int'(out_byte), int'(head_result.data));
				if (payload_count != head_result.count)
					report_mismatch("payload_count", int'(payload_count),
						int'(head_result.count));
			end
			case (ifd_pkg::kind_t'(kind))
				ifd_pkg::KIND_DATA: n_data++;
				ifd_pkg::KIND_ACCEPT: n_accept++;
				ifd_pkg::KIND_REJECT: n_reject++;
				default: n_abort++;
			endcase
			if (int'(payload_count) > top_count)
				top_count = int'(payload_count);
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic put(input logic [7:0] b);
		while (line_bytes.size() >= 64)
			@(negedge clk);
		line_bytes.push_back(b);
		bytes_sent++;
	endtask

	task automatic put_seq(input logic [7:0] seq[]);
		foreach (seq[i])
			put(seq[i]);
	endtask

	task automatic put_body(input logic [7:0] b);
		if (b == ifd_pkg::FLAG_BYTE || b == ifd_pkg::ESC_BYTE) begin
			put(ifd_pkg::ESC_BYTE);
			put(b ^ ifd_pkg::ESC_XOR);
		end else begin
			put(b);
		end
	endtask

	task automatic put_header(input logic [7:0] ctrl);
		put(ifd_pkg::FLAG_BYTE);
		put(ifd_pkg::ADDR_BYTE);
		put(ctrl);
		put(ifd_pkg::ADDR_BYTE ^ ctrl);
	endtask

	// payload bytes lean toward the flag, the escape and the extremes
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(3) != 0)
			return 8'($urandom);
		case ($urandom_range(3))
			0: return ifd_pkg::FLAG_BYTE;
			1: return ifd_pkg::ESC_BYTE;
			2: return 8'h00;
			default: return 8'hFF;
		endcase
	endfunction

	task automatic send_frame(input logic [7:0] ctrl, input int len, input bit corrupt);
		logic [7:0] chk;
		logic [7:0] b;
		chk = 8'h00;
		put_header(ctrl);
		for (int i = 0; i < len; i++) begin
			b = pick_byte();
			put_body(b);
			chk = chk ^ b;
		end
		if (corrupt)
			chk = chk ^ (8'h01 << $urandom_range(7));
		put_body(chk);
		put(ifd_pkg::FLAG_BYTE);
	endtask

	// sender holds back until every owed result has come out
	task automatic drain();
		while (line_bytes.size() != 0 || in_valid)
			@(negedge clk);
		while (due_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int rand_start;
		int sel;
		int n;
		bit paused_a;
		bit paused_b;
		logic [7:0] b;
		paused_a = 1'b0;
		paused_b = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// repeated opening flag, payload extremes, good check
		put_seq('{8'h7E, 8'h7E, 8'h03, 8'h00, 8'h03, 8'h00, 8'hFF, 8'hFF, 8'h7E});
		// empty frame
		put_seq('{8'h7E, 8'h03, 8'h80, 8'h83, 8'h7E});
		// both escapes in the payload
		put_seq('{8'h7E, 8'h03, 8'h80, 8'h83, 8'h7D, 8'h5E, 8'h7D, 8'h5D, 8'h03, 8'h7E});
		// flag in control and check place restarts the header, then flag after escape
		put_seq('{8'h7E, 8'h03, 8'h7E, 8'h03, 8'h00, 8'h7E, 8'h03, 8'h00, 8'h03,
			8'h41, 8'h7D, 8'h7E});
		// wrong address, control and header check
		put_seq('{8'h7E, 8'h05, 8'h7E, 8'h03, 8'h01, 8'h7E, 8'h03, 8'h00, 8'h04});
		// bad payload check, then bad escape with a count
		put_seq('{8'h7E, 8'h03, 8'h00, 8'h03, 8'h12, 8'h34, 8'h00, 8'h7E,
			8'h7E, 8'h03, 8'h00, 8'h03, 8'h12, 8'h34, 8'h56, 8'h7D, 8'h00});
		drain();

		rand_start = bytes_sent;
		while (bytes_sent < rand_start + RANDOM_BYTES) begin
			if (!paused_a && bytes_sent - rand_start >= 300) begin
				drain();
				paused_a = 1'b1;
			end
			if (!paused_b && bytes_sent - rand_start >= 900) begin
				drain();
				paused_b = 1'b1;
			end
			sel = $urandom_range(99);
			if (sel < 65) begin
				if ($urandom_range(9) == 0)
					put(ifd_pkg::FLAG_BYTE);
				n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
				send_frame($urandom_range(1) ? ifd_pkg::CTRL_I1 : ifd_pkg::CTRL_I0, n,
					$urandom_range(99) < 15);
			end else if (sel < 75) begin
				put_header($urandom_range(1) ? ifd_pkg::CTRL_I1 : ifd_pkg::CTRL_I0);
				n = $urandom_range(6);
				for (int i = 0; i < n; i++)
					put_body(pick_byte());
				put(ifd_pkg::ESC_BYTE);
				do
					b = ($urandom_range(3) == 0) ? ifd_pkg::FLAG_BYTE : 8'($urandom);
				while (b == (ifd_pkg::FLAG_BYTE ^ ifd_pkg::ESC_XOR) ||
					b == (ifd_pkg::ESC_BYTE ^ ifd_pkg::ESC_XOR));
				put(b);
			end else if (sel < 80) begin
				put_header($urandom_range(1) ? ifd_pkg::CTRL_I1 : ifd_pkg::CTRL_I0);
				put(ifd_pkg::FLAG_BYTE);
			end else if (sel < 90) begin
				put(ifd_pkg::FLAG_BYTE);
				put($urandom_range(1) ? ifd_pkg::ADDR_BYTE : pick_byte());
				put($urandom_range(1) ? ifd_pkg::CTRL_I0 : pick_byte());
				put(pick_byte());
			end else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					put(pick_byte());
			end
		end

		// one last short good frame
		send_frame(ifd_pkg::CTRL_I1, 3, 1'b0);
		drain();
		repeat (8) @(posedge clk);

		$display("%0d bytes in, %0d payload bytes out, frames: %0d accepted %0d rejected %0d aborted",
			bytes_in, n_data, n_accept, n_reject, n_abort);
		$display("largest payload count seen %0d, %0d mismatches", top_count, mismatches);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/ifd_pkg.sv
sv/info_frame_deframer_top.sv
bench/info_frame_deframer_top_test.sv
